[sv/sbgr_pkg.sv]
// ----------------------------------------------------------------------------
// sbgr_pkg: shared types and constants for the six-button gamepad reader
// Phase codes, script step numbers, state and result structs, button packing.
// ----------------------------------------------------------------------------
package sbgr_pkg;

  localparam int unsigned PIN_COUNT = 6;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned BTN_W     = 12;

  localparam logic [COUNT_W-1:0] SETTLE_RESET = 16'd2500;

  localparam logic [STEP_W-1:0] DET_SAMPLE_HIGH  = 4'd4;
  localparam logic [STEP_W-1:0] DET_SAMPLE_LOW   = 4'd5;
  localparam logic [STEP_W-1:0] DET_LAST         = 4'd7;
  localparam logic [STEP_W-1:0] POLL_SAMPLE_XTRA = 4'd6;
  localparam logic [STEP_W-1:0] POLL_THREE_START = 4'd8;
  localparam logic [STEP_W-1:0] POLL_SAMPLE_LOW  = 4'd9;
  localparam logic [STEP_W-1:0] POLL_LAST        = 4'd10;

  localparam logic [3:0] NIBBLE_ALL = 4'hF;
  localparam logic [3:0] NIBBLE_NONE = 4'h0;

  typedef enum logic [2:0] {
    PH_SETTLE_PRE  = 3'd0,
    PH_DETECT      = 3'd1,
    PH_SETTLE_POST = 3'd2,
    PH_IDLE        = 3'd3,
    PH_POLL        = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [STEP_W-1:0]      step;
    logic [COUNT_W-1:0]     settle_count;
    logic                   six_btn;
    logic [PIN_COUNT-1:0]   sample_first;
    logic [PIN_COUNT-1:0]   sample_second;
    logic [PIN_COUNT-1:0]   sample_extra;
    logic [BTN_W-1:0]       last_buttons;
  } rd_state_t;

  typedef struct packed {
    logic             select_level;
    logic             state_valid;
    logic [BTN_W-1:0] button_word;
    logic             six_button_pad;
    logic             idle;
  } rd_result_t;

  // Invert the active-low samples and place them into the button word.
  function automatic logic [BTN_W-1:0] pack_buttons(
    input logic [PIN_COUNT-1:0] s_first,
    input logic [PIN_COUNT-1:0] s_second,
    input logic [PIN_COUNT-1:0] s_extra,
    input logic                 six_btn
  );
    logic [PIN_COUNT-1:0] d1;
    logic [PIN_COUNT-1:0] d2;
    logic [PIN_COUNT-1:0] d3;
    d1 = ~s_first;
    d2 = ~s_second;
    d3 = six_btn ? ~s_extra : '0;
    return {d2[5], d3[3:0], d1[5:4], d2[4], d1[3:0]};
  endfunction

endpackage

[sv/six_button_gamepad_reader_top.sv]
// ----------------------------------------------------------------------------
// six_button_gamepad_reader_top: select-multiplexed gamepad reader
// Detects three- or six-button pads and polls them one tick per beat.
// ----------------------------------------------------------------------------
// Each input beat is one timing tick (nominally 20 us) carrying the six
// active-low pad lines sampled under the select level from the previous
// result beat, plus a poll request. Every input beat yields exactly one
// result beat in the next cycle: the select level to drive during the next
// tick, a poll-done strobe, the packed 12-bit button word (1 = pressed),
// the detected pad type and an idle flag. After reset the block waits
// settle_ticks ticks, runs detection until the pad answers, waits again,
// and then serves poll requests (three ticks on a three-button pad,
// eleven on a six-button pad). Throughput is one beat per clock; the
// sequencer step is a single combinational pass from the state registers
// into the result register. The input stalls only while a result beat is
// held by out_stall. The user writes settle_ticks through the cfg port only
// while the block is idle, unenforced by the block; it resets to 2500.
module six_button_gamepad_reader_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbgr_pkg::COUNT_W-1:0]    cfg_settle_ticks,
  // tick input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sbgr_pkg::PIN_COUNT-1:0]  in_pad_pins,
  input  logic                            in_poll_request,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_select_level,
  output logic                            out_state_valid,
  output logic [sbgr_pkg::BTN_W-1:0]      out_button_word,
  output logic                            out_six_button_pad,
  output logic                            out_idle
);

  logic [sbgr_pkg::COUNT_W-1:0] settle_ticks_r;
  sbgr_pkg::rd_state_t          state_r;
  sbgr_pkg::rd_state_t          state_nxt;
  sbgr_pkg::rd_result_t         res_nxt;
  sbgr_pkg::rd_result_t         res_r;
  logic                         out_valid_r;
  logic                         in_accept;

  // Config register is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= sbgr_pkg::SETTLE_RESET;
    end else if (cfg_valid) begin
      settle_ticks_r <= cfg_settle_ticks;
    end
  end

  // Hold the input while a result beat waits downstream.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  sbgr_step u_step (
    .cur          (state_r),
    .pad_pins     (in_pad_pins),
    .poll_request (in_poll_request),
    .settle_ticks (settle_ticks_r),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  // Advance the sequencer once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: sbgr_pkg::PH_SETTLE_PRE, default: '0};
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_select_level   = res_r.select_level;
  assign out_state_valid    = res_r.state_valid;
  assign out_button_word    = res_r.button_word;
  assign out_six_button_pad = res_r.six_button_pad;
  assign out_idle           = res_r.idle;

endmodule

[sv/sbgr_step.sv]
// ----------------------------------------------------------------------------
// sbgr_step: one tick of the select sequencer
// Computes next state and the tick's result from current state and pins.
// ----------------------------------------------------------------------------
module sbgr_step (
  input  sbgr_pkg::rd_state_t              cur,
  input  logic [sbgr_pkg::PIN_COUNT-1:0]   pad_pins,
  input  logic                             poll_request,
  input  logic [sbgr_pkg::COUNT_W-1:0]     settle_ticks,
  output sbgr_pkg::rd_state_t              nxt,
  output sbgr_pkg::rd_result_t             res
);

  always_comb begin
    sbgr_pkg::rd_state_t st;
    logic sel;
    logic vld;
    logic done;

    st   = cur;
    sel  = 1'b1;
    vld  = 1'b0;
    done = 1'b0;

    // Settle waits: count up, or fall through into the next phase this tick.
    if (st.phase == sbgr_pkg::PH_SETTLE_PRE || st.phase == sbgr_pkg::PH_SETTLE_POST) begin
      if (st.settle_count < settle_ticks) begin
        st.settle_count = st.settle_count + 1'b1;
        done = 1'b1;
      end else begin
        st.phase = (st.phase == sbgr_pkg::PH_SETTLE_PRE) ? sbgr_pkg::PH_DETECT
                                                         : sbgr_pkg::PH_IDLE;
        st.settle_count = '0;
        st.step = '0;
      end
    end

    if (!done && st.phase == sbgr_pkg::PH_DETECT) begin
      sel = st.step[0];
      if (st.step == sbgr_pkg::DET_SAMPLE_HIGH) begin
        st.sample_first = pad_pins;
      end else if (st.step == sbgr_pkg::DET_SAMPLE_LOW) begin
        st.sample_second = pad_pins;
      end
      if (st.step >= sbgr_pkg::DET_LAST) begin
        st.step = '0;
        if (st.sample_first[3:0] == sbgr_pkg::NIBBLE_ALL) begin
          st.six_btn = (st.sample_second[3:0] == sbgr_pkg::NIBBLE_NONE);
          st.phase = sbgr_pkg::PH_SETTLE_POST;
          st.settle_count = '0;
        end
      end else begin
        st.step = st.step + 1'b1;
      end
      done = 1'b1;
    end

    if (!done && st.phase != sbgr_pkg::PH_POLL) begin
      // Idle; any unused phase code is handled as idle.
      st.phase = sbgr_pkg::PH_IDLE;
      if (poll_request) begin
        st.phase = sbgr_pkg::PH_POLL;
        st.step = st.six_btn ? '0 : sbgr_pkg::POLL_THREE_START;
      end else begin
        done = 1'b1;
      end
    end

    if (!done && st.phase == sbgr_pkg::PH_POLL) begin
      if (st.step >= sbgr_pkg::POLL_LAST) begin
        sel = 1'b1;
        st.sample_first = pad_pins;
        st.last_buttons = sbgr_pkg::pack_buttons(st.sample_first, st.sample_second,
                                                 st.sample_extra, st.six_btn);
        vld = 1'b1;
        st.phase = sbgr_pkg::PH_IDLE;
        st.step = '0;
      end else begin
        sel = st.step[0];
        if (st.step == sbgr_pkg::POLL_SAMPLE_XTRA) begin
          st.sample_extra = pad_pins;
        end else if (st.step == sbgr_pkg::POLL_SAMPLE_LOW) begin
          st.sample_second = pad_pins;
        end
        st.step = st.step + 1'b1;
      end
    end

    nxt = st;
    res.select_level   = sel;
    res.state_valid    = vld;
    res.button_word    = st.last_buttons;
    res.six_button_pad = st.six_btn;
    res.idle           = (st.phase == sbgr_pkg::PH_IDLE);
  end

endmodule
